// ===== hdl/gfcer_pkg.sv =====
// Shared constants, codes and GF(2^8) helpers for the column echelon reduce core.
// No dependencies.
package gfcer_pkg;

  localparam int unsigned MaxRows = 16;
  localparam int unsigned MaxCols = 16;
  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 4;
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned DataW   = 8;
  localparam int unsigned CntW    = 5;

  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpRun   = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpNop   = 2'd3;

  localparam logic [1:0] RegNumRows  = 2'd0;
  localparam logic [1:0] RegNumCols  = 2'd1;
  localparam logic [1:0] RegFieldPly = 2'd2;

  // shift-and-add product, reduced by x^8 + poly
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a;
    for (int unsigned n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// ===== hdl/gfcer_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gfcer_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/gf256_column_echelon_reduce_core.sv =====
// Top level: column echelon reduction over GF(2^8) with an action record.
// Depends on gfcer_pkg and gfcer_ram.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  command | start_i, busy_o, op_i, row_i, col_i, value_i   | in (busy_o out)
//  result  | done_o, reduced_value_o, action_value_o        | out
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in (cfg_ready_o out)
//
// Write and read words are taken every cycle while the core is idle; the result strobe is
// registered and follows in the next cycle (read data comes from the registered RAM port).
// A run word holds busy_o high for the whole elimination: the identity fill of the
// action matrix, then per pivot a search and column swap where needed, the inverse
// search, a scaling and a clear, each element going through the shared RAM read
// address. Its result strobe follows the last step.
// Reset clears control and the registers (16, 16, 0x1d); the RAMs are not
// cleared. Results cannot be stalled, so done_o is a one-cycle strobe.
module gf256_column_echelon_reduce_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               op_i,
  input  logic [gfcer_pkg::RowW-1:0] row_i,
  input  logic [gfcer_pkg::ColW-1:0] col_i,
  input  logic [7:0]               value_i,
  output logic                     done_o,
  output logic [7:0]               reduced_value_o,
  output logic [7:0]               action_value_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [7:0]               cfg_data_i
);
  import gfcer_pkg::*;

  typedef enum logic [19:0] {
    SIdle = 20'd1 << 0,
    SInit = 20'd1 << 1,
    SChk  = 20'd1 << 2,
    SPiv  = 20'd1 << 3,
    SSrch = 20'd1 << 4,
    SSrcW = 20'd1 << 5,
    SSwA  = 20'd1 << 6,
    SSwB  = 20'd1 << 7,
    SSwC  = 20'd1 << 8,
    SSwD  = 20'd1 << 9,
    SInv  = 20'd1 << 10,
    SScA  = 20'd1 << 11,
    SScB  = 20'd1 << 12,
    SClF  = 20'd1 << 13,
    SClFW = 20'd1 << 14,
    SClA  = 20'd1 << 15,
    SClB  = 20'd1 << 16,
    SClC  = 20'd1 << 17,
    SDone = 20'd1 << 18,
    SSpare = 20'd1 << 19
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [7:0]      poly_q, poly_d;
  logic [CntW-1:0] i_q, i_d, skip_q, skip_d, j_q, j_d, k_q, k_d;
  logic            sel_q, sel_d;   // 0: work matrix, 1: action matrix
  logic [7:0]      f_q, f_d, tmp_q, tmp_d, piv_q, piv_d, b_q, b_d;
  logic            done_q, done_d, rv_ok_q, rv_ok_d, av_ok_q, av_ok_d;

  logic [CntW-1:0] m, n, lim, p;
  logic [CntW:0]   ip_sum;
  logic [AddrW-1:0] raddr, waddr;
  logic [7:0]      wdata, work_rd, act_rd, sel_rd;
  logic            wr, we_work, we_act;

  assign m      = (rows_q > CntW'(MaxRows)) ? CntW'(MaxRows) : rows_q;
  assign n      = (cols_q > CntW'(MaxCols)) ? CntW'(MaxCols) : cols_q;
  assign lim    = sel_q ? n : m;
  assign ip_sum = {1'b0, i_q} + {1'b0, skip_q};
  assign p      = ip_sum[CntW-1:0];
  assign sel_rd = sel_q ? act_rd : work_rd;

  assign we_work = wr & ~sel_q;
  assign we_act  = wr & sel_q;

  gfcer_ram #(.Width(8), .Depth(MaxRows * MaxCols)) u_work_ram (
    .clk_i, .we_i(we_work), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(work_rd)
  );

  gfcer_ram #(.Width(8), .Depth(MaxCols * MaxCols)) u_act_ram (
    .clk_i, .we_i(we_act), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(act_rd)
  );

  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    rows_d = rows_q; cols_d = cols_q; poly_d = poly_q;
    i_d = i_q; skip_d = skip_q; j_d = j_q; k_d = k_q; sel_d = sel_q;
    f_d = f_q; tmp_d = tmp_q; piv_d = piv_q; b_d = b_q;
    done_d = 1'b0; rv_ok_d = 1'b0; av_ok_d = 1'b0;
    raddr = '0; waddr = '0; wdata = '0; wr = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegNumRows:  rows_d = cfg_data_i[CntW-1:0];
        RegNumCols:  cols_d = cfg_data_i[CntW-1:0];
        RegFieldPly: poly_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          unique case (op_i)
            OpWrite: begin
              sel_d  = 1'b0;
              waddr  = {row_i, col_i};
              wdata  = value_i;
              wr     = ~sel_q;  // sel is always clear when idle
              done_d = 1'b1;
            end
            OpRun: begin
              i_d = '0; skip_d = '0; j_d = '0; k_d = '0; sel_d = 1'b1;
              state_d = (n != '0) ? SInit : SDone;
            end
            OpRead: begin
              raddr   = {row_i, col_i};
              rv_ok_d = ({1'b0, row_i} < m) && ({1'b0, col_i} < n);
              av_ok_d = ({1'b0, row_i} < n) && ({1'b0, col_i} < n);
              done_d  = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      SInit: begin
        waddr = {k_q[RowW-1:0], j_q[ColW-1:0]};
        wdata = (k_q == j_q) ? 8'd1 : 8'd0;
        wr    = 1'b1;
        if (j_q == n - CntW'(1)) begin
          j_d = '0;
          if (k_q == n - CntW'(1)) begin
            k_d = '0; sel_d = 1'b0; state_d = SChk;
          end else k_d = k_q + CntW'(1);
        end else j_d = j_q + CntW'(1);
      end
      SChk: begin
        sel_d = 1'b0;
        if (i_q < n && ip_sum < {1'b0, m}) begin
          raddr   = {p[RowW-1:0], i_q[ColW-1:0]};
          state_d = SPiv;
        end else state_d = SDone;
      end
      SPiv: begin
        if (work_rd != 8'd0) begin
          piv_d = work_rd; b_d = 8'd1; state_d = SInv;
        end else begin
          j_d = i_q + CntW'(1); state_d = SSrch;
        end
      end
      SSrch: begin
        if (j_q >= n) begin
          skip_d = skip_q + CntW'(1); state_d = SChk;
        end else begin
          raddr = {p[RowW-1:0], j_q[ColW-1:0]}; state_d = SSrcW;
        end
      end
      SSrcW: begin
        if (work_rd != 8'd0) begin
          piv_d = work_rd; sel_d = 1'b0; k_d = '0; state_d = SSwA;
        end else begin
          j_d = j_q + CntW'(1); state_d = SSrch;
        end
      end
      SSwA: begin
        if (k_q >= lim) begin
          k_d = '0;
          if (!sel_q) sel_d = 1'b1;
          else begin
            sel_d = 1'b0; b_d = 8'd1; state_d = SInv;  // pivot taken from search
          end
        end else begin
          raddr = {k_q[RowW-1:0], i_q[ColW-1:0]}; state_d = SSwB;
        end
      end
      SSwB: begin
        tmp_d = sel_rd;
        raddr = {k_q[RowW-1:0], j_q[ColW-1:0]};
        state_d = SSwC;
      end
      SSwC: begin
        waddr = {k_q[RowW-1:0], i_q[ColW-1:0]};
        wdata = sel_rd; wr = 1'b1;
        state_d = SSwD;
      end
      SSwD: begin
        waddr = {k_q[RowW-1:0], j_q[ColW-1:0]};
        wdata = tmp_q; wr = 1'b1;
        k_d = k_q + CntW'(1);
        state_d = SSwA;
      end
      SInv: begin
        if (gf_mul(piv_q, b_q, poly_q) == 8'd1) begin
          f_d = b_q; k_d = '0; sel_d = 1'b0; state_d = SScA;
        end else if (b_q == 8'hff) begin
          f_d = 8'd0; k_d = '0; sel_d = 1'b0; state_d = SScA;
        end else b_d = b_q + 8'd1;
      end
      SScA: begin
        if (k_q >= lim) begin
          k_d = '0;
          if (!sel_q) sel_d = 1'b1;
          else begin
            sel_d = 1'b0; j_d = '0; state_d = SClF;
          end
        end else begin
          raddr = {k_q[RowW-1:0], i_q[ColW-1:0]}; state_d = SScB;
        end
      end
      SScB: begin
        waddr = {k_q[RowW-1:0], i_q[ColW-1:0]};
        wdata = gf_mul(sel_rd, f_q, poly_q); wr = 1'b1;
        k_d = k_q + CntW'(1);
        state_d = SScA;
      end
      SClF: begin
        sel_d = 1'b0;
        if (j_q >= n) begin
          i_d = i_q + CntW'(1); state_d = SChk;
        end else if (j_q == i_q) begin
          j_d = j_q + CntW'(1);
        end else begin
          raddr = {p[RowW-1:0], j_q[ColW-1:0]}; state_d = SClFW;
        end
      end
      SClFW: begin
        f_d = work_rd;
        if (work_rd == 8'd0) begin
          j_d = j_q + CntW'(1); state_d = SClF;
        end else begin
          k_d = '0; state_d = SClA;
        end
      end
      SClA: begin
        if (k_q >= lim) begin
          k_d = '0;
          if (!sel_q) sel_d = 1'b1;
          else begin
            sel_d = 1'b0; j_d = j_q + CntW'(1); state_d = SClF;
          end
        end else begin
          raddr = {k_q[RowW-1:0], i_q[ColW-1:0]}; state_d = SClB;
        end
      end
      SClB: begin
        tmp_d = sel_rd;
        raddr = {k_q[RowW-1:0], j_q[ColW-1:0]};
        state_d = SClC;
      end
      SClC: begin
        waddr = {k_q[RowW-1:0], j_q[ColW-1:0]};
        wdata = sel_rd ^ gf_mul(f_q, tmp_q, poly_q); wr = 1'b1;
        k_d = k_q + CntW'(1);
        state_d = SClA;
      end
      SDone: begin
        sel_d = 1'b0; done_d = 1'b1; state_d = SIdle;
      end
      default: begin
        sel_d = 1'b0; state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rows_q  <= CntW'(16);
      cols_q  <= CntW'(16);
      poly_q  <= 8'h1d;
      i_q <= '0; skip_q <= '0; j_q <= '0; k_q <= '0; sel_q <= 1'b0;
      done_q <= 1'b0; rv_ok_q <= 1'b0; av_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      poly_q  <= poly_d;
      i_q <= i_d; skip_q <= skip_d; j_q <= j_d; k_q <= k_d; sel_q <= sel_d;
      done_q <= done_d; rv_ok_q <= rv_ok_d; av_ok_q <= av_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    tmp_q <= tmp_d;
    piv_q <= piv_d;
    b_q   <= b_d;
  end

  assign busy_o          = (state_q != SIdle);
  assign done_o          = done_q;
  assign reduced_value_o = rv_ok_q ? work_rd : 8'd0;
  assign action_value_o  = av_ok_q ? act_rd : 8'd0;

endmodule

// ===== dv/gfcer_checker.sv =====
// Checker for the column echelon reduce core: mirrors the matrices, predicts each result word
// and compares it with the strobed output. Depends on gfcer_pkg.
module gfcer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_o,
  input  logic [1:0] op_i,
  input  logic [3:0] row_i,
  input  logic [3:0] col_i,
  input  logic [7:0] value_i,
  input  logic       done_o,
  input  logic [7:0] reduced_value_o,
  input  logic [7:0] action_value_o,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfcer_pkg::*;

  typedef struct packed {
    logic [7:0] reduced;
    logic [7:0] action;
  } readback_t;

  logic [7:0] work_m [MaxRows][MaxCols];
  logic [7:0] act_m  [MaxCols][MaxCols];
  logic [4:0] rows_cfg, cols_cfg;
  logic [7:0] poly_cfg;
  readback_t  readback_q [$];

  assign pending_o = readback_q.size();

  function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ poly_cfg) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

  // no inverse under a non-field polynomial: taken as zero
  function automatic logic [7:0] field_inv(logic [7:0] a);
    for (int b = 1; b < 256; b++)
      if (field_mul(a, 8'(b)) == 8'd1) return 8'(b);
    return 8'd0;
  endfunction

  function automatic int eff_rows();
    return (rows_cfg < MaxRows) ? int'(rows_cfg) : MaxRows;
  endfunction

  function automatic int eff_cols();
    return (cols_cfg < MaxCols) ? int'(cols_cfg) : MaxCols;
  endfunction

  task automatic reduce_columns();
    int m, n, piv, skipped, j;
    logic [7:0] tmp, f;
    m = eff_rows();
    n = eff_cols();
    piv = 0;
    skipped = 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) act_m[r][c] = (r == c) ? 8'd1 : 8'd0;
    while (piv < n && piv + skipped < m) begin
      int p;
      p = piv + skipped;
      if (work_m[p][piv] == 0) begin
        for (j = piv + 1; j < n; j++)
          if (work_m[p][j] != 0) break;
        if (j >= n) begin
          skipped++;
          continue;
        end
        for (int k = 0; k < m; k++) begin
          tmp = work_m[k][piv]; work_m[k][piv] = work_m[k][j]; work_m[k][j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
          tmp = act_m[k][piv]; act_m[k][piv] = act_m[k][j]; act_m[k][j] = tmp;
        end
      end
      f = field_inv(work_m[p][piv]);
      for (int k = 0; k < m; k++) work_m[k][piv] = field_mul(work_m[k][piv], f);
      for (int k = 0; k < n; k++) act_m[k][piv] = field_mul(act_m[k][piv], f);
      for (int c = 0; c < n; c++) begin
        if (c == piv) continue;
        f = work_m[p][c];
        if (f == 0) continue;
        for (int k = 0; k < m; k++) work_m[k][c] ^= field_mul(f, work_m[k][piv]);
        for (int k = 0; k < n; k++) act_m[k][c] ^= field_mul(f, act_m[k][piv]);
      end
      piv++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg <= 5'd16;
      cols_cfg <= 5'd16;
      poly_cfg <= 8'h1d;
      fail_cnt_o <= 0;
      readback_q.delete();
    end else begin
      readback_t exp_w, got_w;
      int        errs;
      exp_w = '0;
      errs  = 0;
      if (done_o) begin
        got_w = '{reduced: reduced_value_o, action: action_value_o};
        if (readback_q.size() == 0) begin
          $display("%0t: unexpected result word, actual %h/%h", $time,
                   got_w.reduced, got_w.action);
          errs++;
        end else begin
          exp_w = readback_q.pop_front();
          if (got_w.reduced !== exp_w.reduced) begin
            $display("%0t: reduced_value expected %h actual %h", $time,
                     exp_w.reduced, got_w.reduced);
            errs++;
          end
          if (got_w.action !== exp_w.action) begin
            $display("%0t: action_value expected %h actual %h", $time,
                     exp_w.action, got_w.action);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegNumRows:  rows_cfg <= cfg_data_i[4:0];
          RegNumCols:  cols_cfg <= cfg_data_i[4:0];
          RegFieldPly: poly_cfg <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        exp_w = '0;
        case (op_i)
          OpWrite: work_m[row_i][col_i] = value_i;
          OpRun:   reduce_columns();
          OpRead: begin
            if (row_i < eff_rows() && col_i < eff_cols()) exp_w.reduced = work_m[row_i][col_i];
            if (row_i < eff_cols() && col_i < eff_cols()) exp_w.action = act_m[row_i][col_i];
          end
          default: ;
        endcase
        readback_q.push_back(exp_w);
      end
    end
  end
endmodule

// ===== dv/tb_gf256_column_echelon_reduce_core.sv =====
// Testbench top for the column echelon reduce core: drives command and config words,
// leaves prediction and comparison to gfcer_checker. Depends on gfcer_pkg, the core and the checker.
module tb_gf256_column_echelon_reduce_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gfcer_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [1:0] op_i = OpNop;
  logic [3:0] row_i = '0;
  logic [3:0] col_i = '0;
  logic [7:0] value_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = RegNumRows;
  logic [7:0] cfg_data_i = '0;
  logic       busy_o, done_o, cfg_ready_o;
  logic [7:0] reduced_value_o, action_value_o;
  int         fail_cnt, pending;

  // counters for the closing summary
  int words_sent = 0;
  int runs_sent = 0;
  int cfg_sent = 0;
  int phases_done = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  gf256_column_echelon_reduce_core dut (.*);

  gfcer_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .row_i, .col_i, .value_i,
    .done_o, .reduced_value_o, .action_value_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // mostly back-to-back, some short gaps, the odd long one
  task automatic idle_gap();
    int roll, cycles;
    roll = $urandom_range(0, 99);
    if (roll < 65) cycles = 0;
    else if (roll < 95) cycles = $urandom_range(1, 3);
    else cycles = $urandom_range(10, 40);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_word(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic [7:0] v);
    idle_gap();
    start_i <= 1'b1;
    op_i    <= op;
    row_i   <= r;
    col_i   <= c;
    value_i <= v;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    words_sent++;
    if (op == OpRun) runs_sent++;
  endtask

  // hold off until every outstanding result has been strobed, then let the core settle
  task automatic drain();
    start_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_sent++;
  endtask

  // style 0 dense, 1 sparse, 2 dense with a zeroed row and column (skip and swap)
  task automatic run_phase(logic [4:0] m, logic [4:0] n, logic [7:0] poly, int style,
                           int n_wr, int n_rd);
    int mm, nn, zr, zc;
    logic [7:0] v;
    drain();
    write_reg(RegNumRows, {3'($urandom), m});
    write_reg(RegNumCols, {3'($urandom), n});
    write_reg(RegFieldPly, poly);
    mm = (m == 0) ? 1 : ((m > 16) ? 16 : m);
    nn = (n == 0) ? 1 : ((n > 16) ? 16 : n);
    for (int k = 0; k < n_wr; k++) begin
      v = 8'($urandom);
      if (style == 1 && $urandom_range(0, 3) != 0) v = 8'd0;
      send_word(OpWrite, 4'($urandom_range(0, mm - 1)), 4'($urandom_range(0, nn - 1)), v);
    end
    if (style == 2) begin
      zr = $urandom_range(0, mm - 1);
      zc = $urandom_range(0, nn - 1);
      for (int c = 0; c < nn; c++) send_word(OpWrite, 4'(zr), 4'(c), 8'd0);
      for (int r = 0; r < mm; r++) send_word(OpWrite, 4'(r), 4'(zc), 8'd0);
    end
    send_word(OpRun, 4'($urandom), 4'($urandom), 8'($urandom));
    for (int k = 0; k < n_rd; k++) begin
      case ($urandom_range(0, 9))
        0: send_word(OpNop, 4'($urandom), 4'($urandom), 8'($urandom));
        1: send_word(OpWrite, 4'($urandom), 4'($urandom), 8'($urandom));
        2, 3: send_word(OpRead, 4'($urandom), 4'($urandom), 8'($urandom));
        default: send_word(OpRead, 4'($urandom_range(0, mm - 1)),
                           4'($urandom_range(0, nn - 1)), 8'($urandom));
      endcase
    end
    phases_done++;
  endtask

  function automatic logic [4:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 5'($urandom_range(1, 6));
    if (roll < 85) return 5'($urandom_range(7, 16));
    if (roll < 90) return 5'd16;
    if (roll < 95) return 5'($urandom_range(17, 31));
    return 5'd0;
  endfunction

  function automatic logic [7:0] pick_poly();
    case ($urandom_range(0, 5))
      0: return 8'h1d;
      1: return 8'h2b;
      2: return 8'h00;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // preload every work matrix entry so no later read or run sees an unwritten cell
    for (int r = 0; r < MaxRows; r++)
      for (int c = 0; c < MaxCols; c++)
        send_word(OpWrite, 4'(r), 4'(c),
                  (r == c) ? 8'hff : ((r + c == 15) ? 8'h00 : 8'($urandom)));

    // directed: reset config run, corner reads, no-op
    send_word(OpRun, 4'd0, 4'd0, 8'd0);
    send_word(OpRead, 4'd0, 4'd0, 8'd0);
    send_word(OpRead, 4'd15, 4'd15, 8'hff);
    send_word(OpRead, 4'd15, 4'd0, 8'd0);
    send_word(OpNop, 4'd15, 4'd15, 8'hff);
    // zero sizes, clamped sizes, non-field polynomials, skipped rows
    run_phase(5'd0, 5'd0, 8'h1d, 0, 1, 2);
    run_phase(5'd0, 5'd16, 8'h1d, 0, 0, 2);
    run_phase(5'd31, 5'd31, 8'h00, 0, 2, 2);
    run_phase(5'd1, 5'd1, 8'hff, 1, 1, 2);
    run_phase(5'd4, 5'd3, 8'h1d, 2, 4, 2);

    base = words_sent;
    while (words_sent - base < 340)
      run_phase(pick_size(), pick_size(), pick_poly(), $urandom_range(0, 2),
                $urandom_range(2, 20), $urandom_range(5, 30));

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d command words (%0d reductions) over %0d phases, %0d register writes,",
             words_sent, runs_sent, phases_done, cfg_sent);
    $display("with sizes from zero to clamped and both field and non-field polynomials.");
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
